@@ src/lsbse_pkg.sv @@
// Package for the LSB stego payload extractor: parse phases, record codes,
// extension candidate tables and the small mod-13 helper.
// No dependencies.
package lsbse_pkg;

  typedef enum logic [2:0] {
    PH_CHECKSUM = 3'd0,
    PH_EXTLEN   = 3'd1,
    PH_EXTCHARS = 3'd2,
    PH_HEIGHT   = 3'd3,
    PH_WIDTH    = 3'd4,
    PH_SIZE     = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_IDLE     = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_CHECKSUM = 2'd0;
  localparam logic [1:0] ERR_EXTLEN   = 2'd1;
  localparam logic [1:0] ERR_EXT      = 2'd2;
  localparam logic [1:0] ERR_SIZE     = 2'd3;

  localparam logic [1:0] EXT_TXT  = 2'd0;
  localparam logic [1:0] EXT_PNG  = 2'd1;
  localparam logic [1:0] EXT_JPEG = 2'd2;
  localparam logic [1:0] EXT_JPG  = 2'd3;

  localparam int unsigned NUM_EXT = 4;

  function automatic logic [7:0] cand_len(input logic [1:0] k);
    logic [7:0] len;
    case (k)
      EXT_JPEG: len = 8'd5;
      default:  len = 8'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (i)
      3'd0: c = 8'h2e;
      3'd1: begin
        case (k)
          EXT_TXT: c = 8'h74;
          EXT_PNG: c = 8'h70;
          default: c = 8'h6a;
        endcase
      end
      3'd2: begin
        case (k)
          EXT_TXT: c = 8'h78;
          EXT_PNG: c = 8'h6e;
          default: c = 8'h70;
        endcase
      end
      3'd3: begin
        case (k)
          EXT_TXT:  c = 8'h74;
          EXT_PNG:  c = 8'h67;
          EXT_JPEG: c = 8'h65;
          default:  c = 8'h67;
        endcase
      end
      3'd4: begin
        case (k)
          EXT_JPEG: c = 8'h67;
          default:  c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // remainder by 13 via reciprocal 79/1024, exact for 8-bit inputs
  function automatic logic [3:0] mod13_u8(input logic [7:0] x);
    logic [14:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 15'(x) * 15'd79;
    q = p[14:10];
    r = x - 8'(q) * 8'd13;
    return r[3:0];
  endfunction

endpackage

@@ src/lsb_stego_payload_extractor_core.sv @@
// Flow: a sample word accepted into the input register has its result word (if any)
// registered when the word is taken; taking waits while a held result is not read.
// Throughput: one sample word per cycle while out_ready is held high; the output
// register and the input register are each refilled in the cycle they are emptied.
// Reset: synchronous, active low; parser to the checksum phase, skip_r to 0,
// both stage valids cleared. Single module; depends on lsbse_pkg.
module lsb_stego_payload_extractor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               in_restart,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_payload_byte,
  output logic [1:0]         out_ext_code,
  output logic signed [31:0] out_image_height,
  output logic signed [31:0] out_image_width,
  output logic [31:0]        out_payload_size,
  output logic [1:0]         out_error_code,
  output logic               out_last
);

  logic               s1_valid_r, s1_valid_nxt;
  logic signed [15:0] s1_sample_r;
  logic               s1_restart_r;
  logic               skip_r;

  lsbse_pkg::phase_t  phase_r, phase_nxt, phase_e;
  logic [2:0]  bp_r, bp_nxt, bp_e;
  logic [7:0]  bg_r, bg_nxt, bg_e;
  logic [1:0]  fbi_r, fbi_nxt, fbi_e;
  logic [31:0] fg_r, fg_nxt, fg_e;
  logic [7:0]  ext_len_r, ext_len_nxt, ext_len_e;
  logic [7:0]  ext_idx_r, ext_idx_nxt, ext_idx_e;
  logic [3:0]  flags_r, flags_nxt, flags_e;
  logic [31:0] height_r, height_nxt, height_e;
  logic [31:0] width_r, width_nxt, width_e;
  logic [31:0] br_r, br_nxt, br_e;

  logic        out_valid_r;
  logic [1:0]  kind_r, ext_code_r, err_r;
  logic [7:0]  pbyte_r;
  logic [31:0] oh_r, ow_r, osize_r;
  logic        last_r;

  logic        out_free, s1_take, in_acc;
  logic        use_bit, byte_done;
  logic [7:0]  gather, b;
  logic [31:0] fg_or, word32;
  logic [7:0]  ext_idx_inc;
  logic        ext_done;
  logic [3:0]  flags_chr, flags_fin;
  logic [1:0]  code_e, code_fin;
  logic [3:0]  r_lo, r_hi;
  logic [7:0]  cs_sum;
  logic        cs_ok;

  logic        emit;
  logic [1:0]  kind_c, ext_code_c, err_c;
  logic [7:0]  pbyte_c;
  logic [31:0] oh_c, ow_c, osize_c;
  logic        last_c;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_take   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // restart clears the parser before the sample is used
  always_comb begin
    phase_e   = s1_restart_r ? lsbse_pkg::PH_CHECKSUM : phase_r;
    bp_e      = s1_restart_r ? 3'd0  : bp_r;
    bg_e      = s1_restart_r ? 8'd0  : bg_r;
    fbi_e     = s1_restart_r ? 2'd0  : fbi_r;
    fg_e      = s1_restart_r ? 32'd0 : fg_r;
    ext_len_e = s1_restart_r ? 8'd0  : ext_len_r;
    ext_idx_e = s1_restart_r ? 8'd0  : ext_idx_r;
    flags_e   = s1_restart_r ? 4'hf  : flags_r;
    height_e  = s1_restart_r ? 32'd0 : height_r;
    width_e   = s1_restart_r ? 32'd0 : width_r;
    br_e      = s1_restart_r ? 32'd0 : br_r;
  end

  always_comb begin
    use_bit   = (phase_e != lsbse_pkg::PH_IDLE) &&
                !(skip_r && (s1_sample_r == 16'sd0 || s1_sample_r == 16'sd1));
    gather    = bg_e | (8'(s1_sample_r[0]) << bp_e);
    byte_done = use_bit && (bp_e == 3'd7);
    b         = gather;
    fg_or     = fg_e | (32'(b) << {fbi_e, 3'b000});
    word32    = fg_e | {b, 24'd0};

    r_lo   = lsbse_pkg::mod13_u8(fg_e[7:0]);
    r_hi   = lsbse_pkg::mod13_u8(b);
    cs_sum = 8'(r_lo) + 8'(r_hi) * 8'd9;
    cs_ok  = (lsbse_pkg::mod13_u8(cs_sum) == 4'd0);

    ext_idx_inc = ext_idx_e + 8'd1;
    ext_done    = !(ext_idx_inc < ext_len_e);
    for (int k = 0; k < lsbse_pkg::NUM_EXT; k++) begin
      flags_chr[k] = flags_e[k] &&
        !((ext_idx_e >= lsbse_pkg::cand_len(2'(k))) ||
          (lsbse_pkg::cand_char(2'(k), (ext_idx_e < 8'd5) ? ext_idx_e[2:0] : 3'd0) != b));
      flags_fin[k] = flags_chr[k] && (lsbse_pkg::cand_len(2'(k)) == ext_len_e);
    end

    code_e = lsbse_pkg::EXT_TXT;
    for (int k = lsbse_pkg::NUM_EXT - 1; k >= 0; k--)
      if (flags_e[k]) code_e = 2'(k);
    code_fin = lsbse_pkg::EXT_TXT;
    for (int k = lsbse_pkg::NUM_EXT - 1; k >= 0; k--)
      if (flags_fin[k]) code_fin = 2'(k);
  end

  // next state
  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_take ? 1'b0 : s1_valid_r);
    phase_nxt   = phase_r;
    bp_nxt      = bp_r;
    bg_nxt      = bg_r;
    fbi_nxt     = fbi_r;
    fg_nxt      = fg_r;
    ext_len_nxt = ext_len_r;
    ext_idx_nxt = ext_idx_r;
    flags_nxt   = flags_r;
    height_nxt  = height_r;
    width_nxt   = width_r;
    br_nxt      = br_r;
    if (s1_take) begin
      phase_nxt   = phase_e;
      bp_nxt      = bp_e;
      bg_nxt      = bg_e;
      fbi_nxt     = fbi_e;
      fg_nxt      = fg_e;
      ext_len_nxt = ext_len_e;
      ext_idx_nxt = ext_idx_e;
      flags_nxt   = flags_e;
      height_nxt  = height_e;
      width_nxt   = width_e;
      br_nxt      = br_e;
      if (use_bit) begin
        bg_nxt = gather;
        bp_nxt = bp_e + 3'd1;
      end
      if (byte_done) begin
        bg_nxt = 8'd0;
        case (phase_e)
          lsbse_pkg::PH_CHECKSUM: begin
            if (fbi_e == 2'd1) begin
              fg_nxt    = 32'd0;
              fbi_nxt   = 2'd0;
              phase_nxt = cs_ok ? lsbse_pkg::PH_EXTLEN : lsbse_pkg::PH_IDLE;
            end else begin
              fg_nxt  = fg_or;
              fbi_nxt = fbi_e + 2'd1;
            end
          end
          lsbse_pkg::PH_EXTLEN: begin
            if (b == 8'd0) begin
              phase_nxt = lsbse_pkg::PH_IDLE;
            end else begin
              ext_len_nxt = b;
              ext_idx_nxt = 8'd0;
              flags_nxt   = 4'hf;
              phase_nxt   = lsbse_pkg::PH_EXTCHARS;
            end
          end
          lsbse_pkg::PH_EXTCHARS: begin
            ext_idx_nxt = ext_idx_inc;
            if (!ext_done) begin
              flags_nxt = flags_chr;
            end else begin
              flags_nxt = flags_fin;
              fg_nxt    = 32'd0;
              fbi_nxt   = 2'd0;
              if (flags_fin == 4'd0)
                phase_nxt = lsbse_pkg::PH_IDLE;
              else if (code_fin == lsbse_pkg::EXT_TXT)
                phase_nxt = lsbse_pkg::PH_SIZE;
              else
                phase_nxt = lsbse_pkg::PH_HEIGHT;
            end
          end
          lsbse_pkg::PH_HEIGHT, lsbse_pkg::PH_WIDTH, lsbse_pkg::PH_SIZE: begin
            if (fbi_e == 2'd3) begin
              fg_nxt  = 32'd0;
              fbi_nxt = 2'd0;
              if (phase_e == lsbse_pkg::PH_HEIGHT) begin
                height_nxt = word32;
                phase_nxt  = lsbse_pkg::PH_WIDTH;
              end else if (phase_e == lsbse_pkg::PH_WIDTH) begin
                width_nxt = word32;
                phase_nxt = lsbse_pkg::PH_SIZE;
              end else if (word32 == 32'd0) begin
                phase_nxt = lsbse_pkg::PH_IDLE;
              end else begin
                br_nxt    = word32;
                phase_nxt = lsbse_pkg::PH_PAYLOAD;
              end
            end else begin
              fg_nxt  = fg_or;
              fbi_nxt = fbi_e + 2'd1;
            end
          end
          lsbse_pkg::PH_PAYLOAD: begin
            br_nxt = br_e - 32'd1;
            if (br_e == 32'd1) phase_nxt = lsbse_pkg::PH_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  // result word
  always_comb begin
    emit       = 1'b0;
    kind_c     = lsbse_pkg::KIND_PAYLOAD;
    pbyte_c    = 8'd0;
    ext_code_c = lsbse_pkg::EXT_TXT;
    oh_c       = 32'd0;
    ow_c       = 32'd0;
    osize_c    = 32'd0;
    err_c      = lsbse_pkg::ERR_CHECKSUM;
    last_c     = 1'b0;
    if (s1_take && byte_done) begin
      case (phase_e)
        lsbse_pkg::PH_CHECKSUM: begin
          if (fbi_e == 2'd1 && !cs_ok) begin
            emit   = 1'b1;
            kind_c = lsbse_pkg::KIND_ERROR;
            err_c  = lsbse_pkg::ERR_CHECKSUM;
          end
        end
        lsbse_pkg::PH_EXTLEN: begin
          if (b == 8'd0) begin
            emit   = 1'b1;
            kind_c = lsbse_pkg::KIND_ERROR;
            err_c  = lsbse_pkg::ERR_EXTLEN;
          end
        end
        lsbse_pkg::PH_EXTCHARS: begin
          if (ext_done && flags_fin == 4'd0) begin
            emit   = 1'b1;
            kind_c = lsbse_pkg::KIND_ERROR;
            err_c  = lsbse_pkg::ERR_EXT;
          end
        end
        lsbse_pkg::PH_SIZE: begin
          if (fbi_e == 2'd3) begin
            emit = 1'b1;
            if (word32 == 32'd0) begin
              kind_c = lsbse_pkg::KIND_ERROR;
              err_c  = lsbse_pkg::ERR_SIZE;
            end else begin
              kind_c     = lsbse_pkg::KIND_HEADER;
              ext_code_c = code_e;
              oh_c       = height_e;
              ow_c       = width_e;
              osize_c    = word32;
            end
          end
        end
        lsbse_pkg::PH_PAYLOAD: begin
          emit    = 1'b1;
          kind_c  = lsbse_pkg::KIND_PAYLOAD;
          pbyte_c = b;
          last_c  = (br_e == 32'd1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= lsbse_pkg::PH_CHECKSUM;
      bp_r        <= 3'd0;
      bg_r        <= 8'd0;
      fbi_r       <= 2'd0;
      fg_r        <= 32'd0;
      ext_len_r   <= 8'd0;
      ext_idx_r   <= 8'd0;
      flags_r     <= 4'hf;
      height_r    <= 32'd0;
      width_r     <= 32'd0;
      br_r        <= 32'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) skip_r <= cfg_data;
      if (out_free) out_valid_r <= emit;
      phase_r   <= phase_nxt;
      bp_r      <= bp_nxt;
      bg_r      <= bg_nxt;
      fbi_r     <= fbi_nxt;
      fg_r      <= fg_nxt;
      ext_len_r <= ext_len_nxt;
      ext_idx_r <= ext_idx_nxt;
      flags_r   <= flags_nxt;
      height_r  <= height_nxt;
      width_r   <= width_nxt;
      br_r      <= br_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r  <= in_sample;
      s1_restart_r <= in_restart;
    end
    if (out_free && emit) begin
      kind_r     <= kind_c;
      pbyte_r    <= pbyte_c;
      ext_code_r <= ext_code_c;
      oh_r       <= oh_c;
      ow_r       <= ow_c;
      osize_r    <= osize_c;
      err_r      <= err_c;
      last_r     <= last_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = pbyte_r;
  assign out_ext_code     = ext_code_r;
  assign out_image_height = $signed(oh_r);
  assign out_image_width  = $signed(ow_r);
  assign out_payload_size = osize_r;
  assign out_error_code   = err_r;
  assign out_last         = last_r;

`ifndef NO_ASSERTIONS
  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_kind == lsbse_pkg::KIND_PAYLOAD && out_last)
      |-> (phase_r == lsbse_pkg::PH_IDLE))
    else $error("final payload word delivered while parser not idle");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lsbse_pkg::PH_PAYLOAD) |-> (br_r != 32'd0))
    else $error("payload phase with zero bytes remaining");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_take) |=> (s1_valid_r && $stable(s1_sample_r)))
    else $error("stalled input word lost");

  a_checksum_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lsbse_pkg::PH_CHECKSUM) |-> (fbi_r <= 2'd1))
    else $error("checksum byte index out of range");
`endif

endmodule
